>>> rtl/core/handle_pool_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the handle pool allocator core
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HANDLE_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define HANDLE_POOL_ALLOCATOR_CORE_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define HPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define HPA_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> rtl/core/hpa_pkg.sv
// ----------------------------------------------------------------------------
// hpa_pkg
// Types, codes and sizes shared by the handle pool allocator modules.
// ----------------------------------------------------------------------------
package hpa_pkg;

	localparam int POOL_SLOTS  = 16;
	localparam int MAP_ENTRIES = 32;
	localparam int HANDLE_BITS = 32;
	localparam int HASH_SHIFT  = 4;
	localparam int SLOT_W      = $clog2(POOL_SLOTS);
	localparam int COUNT_W     = $clog2(POOL_SLOTS + 1);
	localparam int CNT_W       = 32;

	localparam logic [COUNT_W-1:0] POOL_SIZE_RESET = COUNT_W'(POOL_SLOTS);

	localparam logic [1:0] OP_INSTALL = 2'd0;
	localparam logic [1:0] OP_ACQUIRE = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_FAIL    = 3'd1;
	localparam logic [2:0] STAT_BLOCK   = 3'd2;
	localparam logic [2:0] STAT_IGNORED = 3'd3;
	localparam logic [2:0] STAT_REJECT  = 3'd4;

	typedef struct packed {
		logic [1:0]             opcode;
		logic [HANDLE_BITS-1:0] handle;
		logic [SLOT_W-1:0]      slot_index;
		logic                   may_wait;
	} req_t;

	typedef struct packed {
		logic [2:0]             status;
		logic [HANDLE_BITS-1:0] handle_out;
		logic [SLOT_W-1:0]      slot_out;
		logic [COUNT_W-1:0]     available;
		logic [COUNT_W-1:0]     in_use;
		logic [CNT_W-1:0]       acquire_count;
		logic [CNT_W-1:0]       release_count;
		logic [CNT_W-1:0]       failure_count;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clear_wr;
		logic probe_next;
		logic probe_end;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] in_op;
		logic       in_pre_ok;
		logic       stack_empty;
		logic       probe_hit;
		logic       probe_empty;
		logic       probe_last;
		logic       clear_last;
		logic       out_free;
	} sts_t;

endpackage

>>> rtl/core/hpa_ram.sv
// ----------------------------------------------------------------------------
// hpa_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module hpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/hpa_ctrl.sv
// ----------------------------------------------------------------------------
// hpa_ctrl
// Sequencer for the allocator: map clearing, dispatch, probing and commit.
// ----------------------------------------------------------------------------
module hpa_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	input  hpa_pkg::sts_t sts,
	output hpa_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_POP,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					unique case (sts.in_op)
						hpa_pkg::OP_INSTALL, hpa_pkg::OP_RELEASE: begin
							state_d = sts.in_pre_ok ? S_PROBE_RD : S_FINISH;
						end
						hpa_pkg::OP_ACQUIRE: begin
							state_d = sts.stack_empty ? S_FINISH : S_POP;
						end
						default: begin
							state_d = S_FINISH;
						end
					endcase
				end
			end
			S_PROBE_RD: begin
				state_d = S_PROBE_CHK;
			end
			S_PROBE_CHK: begin
				if (sts.probe_hit || sts.probe_empty || sts.probe_last) begin
					cmd.probe_end = 1'b1;
					state_d       = S_FINISH;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = S_PROBE_RD;
				end
			end
			S_POP: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

>>> rtl/core/hpa_datapath.sv
// ----------------------------------------------------------------------------
// hpa_datapath
// Pool state, hash map, free stack, counters and the result register.
// ----------------------------------------------------------------------------
module hpa_datapath #(
	parameter int MAP_ENTRIES = hpa_pkg::MAP_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hpa_pkg::COUNT_W-1:0] cfg_data,
	input  hpa_pkg::req_t               req,
	input  hpa_pkg::cmd_t               cmd,
	output hpa_pkg::sts_t               sts,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output hpa_pkg::rsp_t               rsp
);

	localparam int MAP_IW  = $clog2(MAP_ENTRIES);
	localparam int SIZE_W  = MAP_IW + 1;
	localparam int NEED_W  = hpa_pkg::COUNT_W + 1;
	localparam int CMP_W   = (SIZE_W > NEED_W) ? SIZE_W : NEED_W;
	localparam int SLOT_W  = hpa_pkg::SLOT_W;
	localparam int TOP_W   = hpa_pkg::COUNT_W;
	localparam int HB      = hpa_pkg::HANDLE_BITS;
	localparam int CNT_W   = hpa_pkg::CNT_W;
	localparam int NSLOTS  = hpa_pkg::POOL_SLOTS;

	localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(NSLOTS);
	localparam logic [CNT_W-1:0] CNT_MAX  = '1;

	logic [TOP_W-1:0]  pool_size_q;
	hpa_pkg::req_t     item_q;
	logic [TOP_W-1:0]  top_q;
	logic [NSLOTS-1:0] installed_q;
	logic [NSLOTS-1:0] busy_q;
	logic [CNT_W-1:0]  acq_q;
	logic [CNT_W-1:0]  rel_q;
	logic [CNT_W-1:0]  fail_q;
	logic [MAP_IW-1:0] idx_q;
	logic [SIZE_W-1:0] n_q;
	logic              pre_q;
	logic              hit_q;
	logic              empty_q;
	logic [MAP_IW-1:0] clr_q;
	hpa_pkg::rsp_t     rsp_q;
	logic              rsp_valid_q;

	logic [TOP_W-1:0]  pool_eff;
	logic [CMP_W-1:0]  size_acc;
	logic [SIZE_W-1:0] bucket_count;
	logic [MAP_IW-1:0] map_mask;
	logic [MAP_IW-1:0] req_hash;

	logic              map_we;
	logic [MAP_IW-1:0] map_waddr;
	logic [HB+SLOT_W-1:0] map_wdata;
	logic [HB+SLOT_W-1:0] map_rd;
	logic [HB-1:0]     map_key;
	logic [SLOT_W-1:0] map_slot;

	logic              stack_we;
	logic [SLOT_W-1:0] stack_wdata;
	logic [SLOT_W-1:0] stack_rd;
	logic [HB-1:0]     handle_rd;

	logic              install_ok;
	logic              release_ok;
	logic              acq_ok;
	logic              acq_fail;
	logic [TOP_W-1:0]  top_d;
	hpa_pkg::rsp_t     rsp_d;

	// A zero pool size acts as one slot, oversized values as the full pool.
	always_comb begin
		if (pool_size_q == '0) begin
			pool_eff = TOP_W'(1);
		end else if (pool_size_q > TOP_FULL) begin
			pool_eff = TOP_FULL;
		end else begin
			pool_eff = pool_size_q;
		end
	end

	// Map size is the smallest power of two that holds twice the pool, capped at MAP_ENTRIES.
	always_comb begin
		size_acc = CMP_W'(2);
		for (int i = 0; i < MAP_IW; i++) begin
			if (size_acc < CMP_W'({pool_eff, 1'b0}) && size_acc < CMP_W'(MAP_ENTRIES)) begin
				size_acc = size_acc << 1;
			end
		end
	end

	assign bucket_count = SIZE_W'(size_acc);
	assign map_mask = MAP_IW'(bucket_count - SIZE_W'(1));
	assign req_hash = req.handle[hpa_pkg::HASH_SHIFT +: MAP_IW] & map_mask;

	assign map_key  = map_rd[HB-1:0];
	assign map_slot = map_rd[HB +: SLOT_W];

	// Map words hold key and slot together; a zero key marks an empty bucket.
	assign map_we    = cmd.clear_wr || (cmd.commit && install_ok);
	assign map_waddr = cmd.clear_wr ? clr_q : idx_q;
	assign map_wdata = cmd.clear_wr ? '0 : {item_q.slot_index, item_q.handle};

	hpa_ram #(.WIDTH(HB + SLOT_W), .DEPTH(MAP_ENTRIES)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (idx_q),
		.rdata (map_rd)
	);

	assign stack_we    = cmd.commit && (install_ok || release_ok);
	assign stack_wdata = install_ok ? item_q.slot_index : map_slot;

	// The read side shows the registered top entry of the stack while it is not empty.
	hpa_ram #(.WIDTH(SLOT_W), .DEPTH(NSLOTS)) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (top_q[SLOT_W-1:0]),
		.wdata (stack_wdata),
		.raddr (SLOT_W'(top_q - TOP_W'(1))),
		.rdata (stack_rd)
	);

	hpa_ram #(.WIDTH(HB), .DEPTH(NSLOTS)) u_handle_ram (
		.clk   (clk),
		.we    (cmd.commit && install_ok),
		.waddr (item_q.slot_index),
		.wdata (item_q.handle),
		.raddr (stack_rd),
		.rdata (handle_rd)
	);

	assign install_ok = (item_q.opcode == hpa_pkg::OP_INSTALL) && pre_q && empty_q;
	assign release_ok = (item_q.opcode == hpa_pkg::OP_RELEASE) && pre_q && hit_q
		&& busy_q[map_slot] && (top_q < TOP_FULL);
	assign acq_ok     = (item_q.opcode == hpa_pkg::OP_ACQUIRE) && (top_q != '0);
	assign acq_fail   = (item_q.opcode == hpa_pkg::OP_ACQUIRE) && (top_q == '0)
		&& !item_q.may_wait;

	always_comb begin
		if (install_ok || release_ok) begin
			top_d = top_q + TOP_W'(1);
		end else if (acq_ok) begin
			top_d = top_q - TOP_W'(1);
		end else begin
			top_d = top_q;
		end
	end

	always_comb begin
		rsp_d            = '0;
		rsp_d.status     = hpa_pkg::STAT_IGNORED;
		unique case (item_q.opcode)
			hpa_pkg::OP_INSTALL: begin
				rsp_d.status   = install_ok ? hpa_pkg::STAT_OK : hpa_pkg::STAT_REJECT;
				rsp_d.slot_out = item_q.slot_index;
			end
			hpa_pkg::OP_ACQUIRE: begin
				if (acq_ok) begin
					rsp_d.status     = hpa_pkg::STAT_OK;
					rsp_d.slot_out   = stack_rd;
					rsp_d.handle_out = handle_rd;
				end else begin
					rsp_d.status = item_q.may_wait ? hpa_pkg::STAT_BLOCK : hpa_pkg::STAT_FAIL;
				end
			end
			hpa_pkg::OP_RELEASE: begin
				if (release_ok) begin
					rsp_d.status   = hpa_pkg::STAT_OK;
					rsp_d.slot_out = map_slot;
				end
			end
			default: begin
				rsp_d.status = hpa_pkg::STAT_IGNORED;
			end
		endcase
		rsp_d.available     = top_d;
		rsp_d.in_use        = (pool_eff > top_d) ? (pool_eff - top_d) : '0;
		rsp_d.acquire_count = (acq_ok && acq_q != CNT_MAX) ? acq_q + CNT_W'(1) : acq_q;
		rsp_d.release_count = (release_ok && rel_q != CNT_MAX) ? rel_q + CNT_W'(1) : rel_q;
		rsp_d.failure_count = (acq_fail && fail_q != CNT_MAX) ? fail_q + CNT_W'(1) : fail_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= hpa_pkg::POOL_SIZE_RESET;
			top_q       <= '0;
			installed_q <= '0;
			busy_q      <= '0;
			acq_q       <= '0;
			rel_q       <= '0;
			fail_q      <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				pool_size_q <= cfg_data;
			end
			if (cmd.clear_wr) begin
				clr_q <= clr_q + MAP_IW'(1);
			end
			if (cmd.commit) begin
				top_q       <= top_d;
				acq_q       <= rsp_d.acquire_count;
				rel_q       <= rsp_d.release_count;
				fail_q      <= rsp_d.failure_count;
				rsp_valid_q <= 1'b1;
				if (install_ok) begin
					installed_q[item_q.slot_index] <= 1'b1;
					busy_q[item_q.slot_index]      <= 1'b0;
				end
				if (acq_ok) begin
					busy_q[stack_rd] <= 1'b1;
				end
				if (release_ok) begin
					busy_q[map_slot] <= 1'b0;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item, probe and response registers carry payload only.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= req;
			idx_q   <= req_hash;
			n_q     <= '0;
			pre_q   <= sts.in_pre_ok;
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end
		if (cmd.probe_next) begin
			idx_q <= (idx_q + MAP_IW'(1)) & map_mask;
			n_q   <= n_q + SIZE_W'(1);
		end
		if (cmd.probe_end) begin
			hit_q   <= sts.probe_hit;
			empty_q <= sts.probe_empty;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		sts             = '0;
		sts.in_op       = req.opcode;
		sts.stack_empty = (top_q == '0);
		unique case (req.opcode)
			hpa_pkg::OP_INSTALL: begin
				sts.in_pre_ok = (req.handle != '0)
					&& (TOP_W'(req.slot_index) < pool_eff)
					&& !installed_q[req.slot_index]
					&& (top_q < TOP_FULL);
			end
			hpa_pkg::OP_RELEASE: begin
				sts.in_pre_ok = (req.handle != '0);
			end
			default: begin
				sts.in_pre_ok = 1'b0;
			end
		endcase
		sts.probe_hit   = (map_key == item_q.handle);
		sts.probe_empty = (map_key == '0);
		sts.probe_last  = ((n_q + SIZE_W'(1)) == bucket_count);
		sts.clear_last  = (clr_q == MAP_IW'(MAP_ENTRIES - 1));
		sts.out_free    = !rsp_valid_q || rsp_ready;
	end

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> rtl/core/handle_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// handle_pool_allocator_core
// Handle slot pool with a LIFO free stack and a linear-probe handle map.
// ----------------------------------------------------------------------------
// After reset the block first clears its hash map, one bucket per cycle, and
// takes no request until every bucket is clear; configuration writes are taken at
// any time. Every request gives one response. An install or release reads the
// map bucket by bucket; each probe is a read of the map RAM followed by a
// compare of its registered output. An acquire that finds a free slot does a
// stack read, then a handle read; an acquire on an empty pool, a release of
// handle zero, a rejected install caught before probing and an unknown opcode
// go straight to the response. The response register lets the next request in
// while a response still waits to be taken.
module handle_pool_allocator_core #(
	parameter int MAP_ENTRIES = hpa_pkg::MAP_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hpa_pkg::COUNT_W-1:0] cfg_data,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  hpa_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output hpa_pkg::rsp_t               rsp
);

	hpa_pkg::cmd_t cmd;
	hpa_pkg::sts_t sts;

	hpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hpa_datapath #(.MAP_ENTRIES(MAP_ENTRIES)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

>>> rtl/core/hpa_checker.sv
// ----------------------------------------------------------------------------
// hpa_checker
// Port-level checks on the allocator responses, bound to the top level.
// ----------------------------------------------------------------------------
`include "handle_pool_allocator_core_defines.svh"

module hpa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input hpa_pkg::rsp_t rsp
);

	logic       rsp_idle_fail;
	logic       rsp_stall;
	logic       rsp_grant;
	logic       fail_uncounted;
	logic [5:0] slot_sum;

	// A failed, blocked or ignored response carries neither handle nor slot; a rejected install echoes its slot.
	assign rsp_idle_fail = (rsp.status == hpa_pkg::STAT_FAIL)
		|| (rsp.status == hpa_pkg::STAT_BLOCK)
		|| (rsp.status == hpa_pkg::STAT_IGNORED);

	assign rsp_stall      = rsp_valid && !rsp_ready;
	assign rsp_grant      = (rsp.handle_out != '0) || (rsp.slot_out != '0);
	assign fail_uncounted = (rsp.status == hpa_pkg::STAT_FAIL) && (rsp.failure_count == '0);
	assign slot_sum       = 6'(rsp.available) + 6'(rsp.in_use);

	`HPA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp), "response moved while stalled")
	`HPA_ASSERT(a_pool_sum, rsp_valid |-> slot_sum <= 6'(hpa_pkg::POOL_SLOTS), "slots exceed the pool")
	`HPA_ASSERT(a_no_grant, rsp_valid && rsp_idle_fail |-> !rsp_grant, "failed response has a grant")
	`HPA_ASSERT_NEVER(a_fail_cnt, rsp_valid && fail_uncounted, "failed acquire without a count")

endmodule

bind handle_pool_allocator_core hpa_checker u_hpa_checker (.*);
